// ----- sv/chained_free_block_stack_assert.svh -----
// assertion macros for the chained free block stack
`ifndef CHAINED_FREE_BLOCK_STACK_ASSERT_SVH
`define CHAINED_FREE_BLOCK_STACK_ASSERT_SVH
`ifndef SYNTH
`define CFB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CFB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFB_ASSERT_IMPL(name, ante, cons, msg)
`define CFB_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- sv/cfb_pkg.sv -----
// types and constants shared by the free block stack modules
package cfb_pkg;

  localparam int CNT_W       = 6;
  localparam int WORD_W      = 32;
  localparam int OP_W        = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CFG_ADDR_W-1:0] CFG_DATA_FIRST  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_SIZE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CACHE_DEPTH = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_REFILL_CNT = 3'd2,
    OP_REFILL_ENT = 3'd3,
    OP_SPILL_ACK  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_SPILL = 2'd2,
    KIND_FREE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_IO_ERROR  = 2'd2,
    ST_BAD_BLOCK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_SP_RD = 2'd2,
    S_SP_EM = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COUNT   = 2'd1,
    MODE_ENTRIES = 2'd2,
    MODE_ACK     = 2'd3
  } mode_t;

  typedef enum logic {RD_POP = 1'b0, RD_SPILL = 1'b1} rd_sel_t;

  typedef enum logic [1:0] {
    WR_SENTINEL = 2'd0,
    WR_PUSH     = 2'd1,
    WR_REFILL   = 2'd2,
    WR_ACK      = 2'd3
  } wr_sel_t;

  typedef enum logic [2:0] {
    CNT_HOLD = 3'd0,
    CNT_DEC  = 3'd1,
    CNT_INC  = 3'd2,
    CNT_ZERO = 3'd3,
    CNT_ONE  = 3'd4,
    CNT_LOAD = 3'd5
  } cnt_op_t;

  typedef enum logic [1:0] {
    FREE_HOLD = 2'd0,
    FREE_DEC  = 2'd1,
    FREE_INC  = 2'd2
  } free_op_t;

  typedef enum logic [1:0] {
    PEND_HOLD  = 2'd0,
    PEND_RDATA = 2'd1,
    PEND_VALUE = 2'd2
  } pend_op_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_t;

  typedef enum logic [2:0] {
    BLK_ZERO    = 3'd0,
    BLK_RDATA   = 3'd1,
    BLK_VALUE   = 3'd2,
    BLK_PENDING = 3'd3,
    BLK_COUNT   = 3'd4
  } blk_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    cnt_op_t  cnt_op;
    free_op_t free_op;
    logic     set_dirty;
    pend_op_t pend_op;
    idx_op_t  pos_op;
    idx_op_t  sp_op;
    logic     emit;
    kind_t    kind;
    status_t  status;
    blk_sel_t blk_sel;
    logic     idx_spill;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            count_zero;
    logic            count_one;
    logic            count_ge_depth;
    logic            val_in_range;
    logic            val_gt_depth;
    logic            rd_zero;
    logic            rd_in_range;
    logic            pos_last;
    logic            sp_last;
    logic            out_free;
  } stat_t;

endpackage

// ----- sv/cfb_dp.sv -----
// datapath: cache memory, counters, config registers and result register
module cfb_dp import cfb_pkg::*; #(
  parameter int CACHE_DEPTH = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [OP_W-1:0]       in_op,
  input  logic [WORD_W-1:0]     in_value,
  input  logic                  in_err,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]     cfg_wdata,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [1:0]            out_kind,
  output logic [1:0]            out_status,
  output logic [WORD_W-1:0]     out_block,
  output logic [CNT_W-1:0]      out_word_index,
  output logic                  out_last,
  output logic [WORD_W-1:0]     out_free_total,
  output logic                  out_dirty
);

  localparam int ADDR_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(CACHE_DEPTH);

  logic [WORD_W-1:0] data_first_r, volume_size_r;
  logic [CNT_W-1:0]  depth_cfg_r;
  logic [CNT_W-1:0]  depth;

  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] value_r;
  logic              err_r;

  logic [WORD_W-1:0] stack_r [CACHE_DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [CNT_W-1:0]  cnt_m1;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] free_r, free_nxt;
  logic              dirty_r, dirty_nxt;
  logic [WORD_W-1:0] pending_r, pending_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  sp_r, sp_nxt;
  logic [WORD_W-1:0] emit_block;

  logic              out_valid_r;
  kind_t             out_kind_r;
  status_t           out_status_r;
  logic [WORD_W-1:0] out_block_r;
  logic [CNT_W-1:0]  out_idx_r;
  logic              out_last_r;
  logic [WORD_W-1:0] out_free_r;
  logic              out_dirty_r;

  // a depth of zero acts as one, anything above the memory as the memory
  always_comb begin
    if (depth_cfg_r == '0) begin
      depth = CNT_W'(1);
    end else if (depth_cfg_r > DEPTH_MAX) begin
      depth = DEPTH_MAX;
    end else begin
      depth = depth_cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_first_r  <= WORD_W'(2);
      volume_size_r <= '0;
      depth_cfg_r   <= CNT_W'(50);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DATA_FIRST:  data_first_r  <= cfg_wdata;
        CFG_VOLUME_SIZE: volume_size_r <= cfg_wdata;
        CFG_CACHE_DEPTH: depth_cfg_r   <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= in_op;
      value_r <= in_value;
      err_r   <= in_err;
    end
  end

  assign cnt_m1 = count_r - CNT_W'(1);

  always_comb begin
    if (cmd.rd_sel == RD_SPILL) begin
      rd_addr = sp_r[ADDR_W-1:0];
    end else if (count_r == '0) begin
      rd_addr = '0;
    end else begin
      rd_addr = cnt_m1[ADDR_W-1:0];
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_SENTINEL: begin
        wr_addr = '0;
        wr_data = '0;
      end
      WR_PUSH: begin
        wr_addr = count_r[ADDR_W-1:0];
        wr_data = value_r;
      end
      WR_REFILL: begin
        wr_addr = pos_r[ADDR_W-1:0];
        wr_data = value_r;
      end
      WR_ACK: begin
        wr_addr = '0;
        wr_data = pending_r;
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      stack_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= stack_r[rd_addr];
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_DEC:  count_nxt = cnt_m1;
      CNT_INC:  count_nxt = count_r + CNT_W'(1);
      CNT_ZERO: count_nxt = '0;
      CNT_ONE:  count_nxt = CNT_W'(1);
      CNT_LOAD: count_nxt = value_r[CNT_W-1:0];
      default:  count_nxt = count_r;
    endcase

    // free count saturates at both ends
    case (cmd.free_op)
      FREE_DEC: free_nxt = (free_r != '0) ? free_r - WORD_W'(1) : free_r;
      FREE_INC: free_nxt = (free_r != '1) ? free_r + WORD_W'(1) : free_r;
      default:  free_nxt = free_r;
    endcase

    dirty_nxt = dirty_r | cmd.set_dirty;

    case (cmd.pend_op)
      PEND_RDATA: pending_nxt = rdata_r;
      PEND_VALUE: pending_nxt = value_r;
      default:    pending_nxt = pending_r;
    endcase

    case (cmd.pos_op)
      IDX_CLR: pos_nxt = '0;
      IDX_INC: pos_nxt = pos_r + CNT_W'(1);
      default: pos_nxt = pos_r;
    endcase

    case (cmd.sp_op)
      IDX_CLR: sp_nxt = '0;
      IDX_INC: sp_nxt = sp_r + CNT_W'(1);
      default: sp_nxt = sp_r;
    endcase

    case (cmd.blk_sel)
      BLK_RDATA:   emit_block = rdata_r;
      BLK_VALUE:   emit_block = value_r;
      BLK_PENDING: emit_block = pending_r;
      BLK_COUNT:   emit_block = {{(WORD_W-CNT_W){1'b0}}, count_r};
      default:     emit_block = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      free_r    <= '0;
      dirty_r   <= 1'b0;
      pending_r <= '0;
      pos_r     <= '0;
      sp_r      <= '0;
    end else begin
      count_r   <= count_nxt;
      free_r    <= free_nxt;
      dirty_r   <= dirty_nxt;
      pending_r <= pending_nxt;
      pos_r     <= pos_nxt;
      sp_r      <= sp_nxt;
    end
  end

  // single result register, reloaded on the cycle its beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_status_r <= cmd.status;
      out_block_r  <= emit_block;
      out_idx_r    <= cmd.idx_spill ? sp_r + CNT_W'(1) : '0;
      out_last_r   <= cmd.last;
      out_free_r   <= free_nxt;
      out_dirty_r  <= dirty_nxt;
    end
  end

  always_comb begin
    stat.op             = op_r;
    stat.err            = err_r;
    stat.count_zero     = (count_r == '0);
    stat.count_one      = (count_r == CNT_W'(1));
    stat.count_ge_depth = (count_r >= depth);
    stat.val_in_range   = (value_r >= data_first_r) && (value_r < volume_size_r);
    stat.val_gt_depth   = (value_r > {{(WORD_W-CNT_W){1'b0}}, depth});
    stat.rd_zero        = (rdata_r == '0);
    stat.rd_in_range    = (rdata_r >= data_first_r) && (rdata_r < volume_size_r);
    stat.pos_last       = ({1'b0, pos_r} + (CNT_W+1)'(1)) >= {1'b0, depth};
    stat.sp_last        = ((sp_r + CNT_W'(1)) == depth);
    stat.out_free       = !out_valid_r || out_tready;
  end

  assign out_tvalid     = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_status     = out_status_r;
  assign out_block      = out_block_r;
  assign out_word_index = out_idx_r;
  assign out_last       = out_last_r;
  assign out_free_total = out_free_r;
  assign out_dirty      = out_dirty_r;

endmodule

// ----- sv/cfb_ctrl.sv -----
// controller: sequencing state machine and host wait mode
`include "chained_free_block_stack_assert.svh"
module cfb_ctrl import cfb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_IDLE;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          // start the pop read right away, the top entry is known
          cmd.latch_in = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_POP;
          state_nxt    = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        if (mode_r == MODE_IDLE && stat.op == OP_ALLOC) begin
          if (!stat.out_free) begin
            state_nxt = S_EXEC;
          end else begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.kind = KIND_ALLOC;
            if (stat.count_zero) begin
              cmd.status = ST_NO_SPACE;
            end else begin
              cmd.cnt_op = CNT_DEC;
              if (stat.rd_zero) begin
                cmd.status = ST_NO_SPACE;
              end else if (!stat.rd_in_range) begin
                cmd.status = ST_BAD_BLOCK;
              end else if (stat.count_one) begin
                // bottom entry is the next chain block
                cmd.pend_op = PEND_RDATA;
                cmd.kind    = KIND_FETCH;
                cmd.blk_sel = BLK_RDATA;
                mode_nxt    = MODE_COUNT;
              end else begin
                cmd.free_op   = FREE_DEC;
                cmd.set_dirty = 1'b1;
                cmd.blk_sel   = BLK_RDATA;
              end
            end
          end
        end else if (mode_r == MODE_IDLE && stat.op == OP_FREE) begin
          if (!stat.val_in_range) begin
            if (!stat.out_free) begin
              state_nxt = S_EXEC;
            end else begin
              cmd.emit    = 1'b1;
              cmd.last    = 1'b1;
              cmd.kind    = KIND_FREE;
              cmd.status  = ST_BAD_BLOCK;
              cmd.blk_sel = BLK_VALUE;
            end
          end else if (stat.count_zero) begin
            // end of chain marker first, then run the free again
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SENTINEL;
            cmd.cnt_op = CNT_ONE;
            state_nxt  = S_EXEC;
          end else if (stat.count_ge_depth) begin
            if (!stat.out_free) begin
              state_nxt = S_EXEC;
            end else begin
              cmd.emit    = 1'b1;
              cmd.kind    = KIND_SPILL;
              cmd.blk_sel = BLK_COUNT;
              cmd.pend_op = PEND_VALUE;
              cmd.sp_op   = IDX_CLR;
              mode_nxt    = MODE_ACK;
              state_nxt   = S_SP_RD;
            end
          end else if (!stat.out_free) begin
            state_nxt = S_EXEC;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_PUSH;
            cmd.cnt_op  = CNT_INC;
            cmd.free_op = FREE_INC;
            cmd.emit    = 1'b1;
            cmd.last    = 1'b1;
            cmd.kind    = KIND_FREE;
            cmd.blk_sel = BLK_VALUE;
          end
        end else if ((mode_r == MODE_COUNT && stat.op == OP_REFILL_CNT) ||
                     (mode_r == MODE_ENTRIES && stat.op == OP_REFILL_ENT)) begin
          if (stat.err || (mode_r == MODE_COUNT && stat.val_gt_depth)) begin
            if (!stat.out_free) begin
              state_nxt = S_EXEC;
            end else begin
              cmd.cnt_op = CNT_ZERO;
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.kind   = KIND_ALLOC;
              cmd.status = ST_IO_ERROR;
              mode_nxt   = MODE_IDLE;
            end
          end else if (mode_r == MODE_COUNT) begin
            cmd.cnt_op = CNT_LOAD;
            cmd.pos_op = IDX_CLR;
            mode_nxt   = MODE_ENTRIES;
          end else if (!stat.pos_last) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_REFILL;
            cmd.pos_op = IDX_INC;
          end else if (!stat.out_free) begin
            state_nxt = S_EXEC;
          end else begin
            // last entry in: the deferred alloc answer goes out now
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_REFILL;
            cmd.pos_op    = IDX_INC;
            cmd.free_op   = FREE_DEC;
            cmd.set_dirty = 1'b1;
            cmd.emit      = 1'b1;
            cmd.last      = 1'b1;
            cmd.kind      = KIND_ALLOC;
            cmd.blk_sel   = BLK_PENDING;
            mode_nxt      = MODE_IDLE;
          end
        end else if (mode_r == MODE_ACK && stat.op == OP_SPILL_ACK) begin
          if (!stat.out_free) begin
            state_nxt = S_EXEC;
          end else begin
            cmd.emit    = 1'b1;
            cmd.last    = 1'b1;
            cmd.kind    = KIND_FREE;
            cmd.blk_sel = BLK_PENDING;
            mode_nxt    = MODE_IDLE;
            if (stat.err) begin
              // failed write: the block is leaked
              cmd.status = ST_IO_ERROR;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WR_ACK;
              cmd.cnt_op  = CNT_ONE;
              cmd.free_op = FREE_INC;
            end
          end
        end
      end

      S_SP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SPILL;
        state_nxt  = S_SP_EM;
      end

      S_SP_EM: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_SPILL;
          cmd.blk_sel   = BLK_RDATA;
          cmd.idx_spill = 1'b1;
          cmd.last      = stat.sp_last;
          if (stat.sp_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.sp_op = IDX_INC;
            state_nxt = S_SP_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `CFB_ASSERT_IMPL(a_emit_needs_slot, cmd.emit, stat.out_free, "result written over a waiting beat")
  `CFB_ASSERT_NEXT(a_spill_ends_in_ack, state_r == S_SP_EM && cmd.emit && stat.sp_last, state_r == S_IDLE && mode_r == MODE_ACK, "spill did not leave the block waiting for ack")
  `CFB_ASSERT_IMPL(a_spill_mode, state_r == S_SP_RD || state_r == S_SP_EM, mode_r == MODE_ACK, "spill walk outside ack wait")

endmodule

// ----- sv/chained_free_block_stack.sv -----
// Free block cache of a chained free list: a stack of block numbers in a memory.
// Input channel in_*: one beat per command; in_tuser carries the operation
// (alloc, free, refill count, refill entry, spill ack), in_tdata the value and
// the host io error flag. Result channel out_*: out_tuser gives the result kind,
// out_tlast marks the last result caused by one input beat. Config port cfg_*
// writes data_first, volume_size and cache_depth; the user must do so only while
// the block is idle, the block does not enforce it. A beat is captured with the pop
// read when idle, then executed. A free on an empty cache writes the end of
// chain marker first, then executes again. A spill emits the cache count, then
// walks the cache through its single read port, emitting each entry read.
// The block can take the next beat while a result still waits on out_tready; a
// stalled receiver holds the block only when a new result is ready to go.
// Reset clears the count, free total, dirty mark and wait mode at once; the
// cache memory is not cleared and needs no clearing pass.
module chained_free_block_stack import cfb_pkg::*; #(
  parameter int CACHE_DEPTH = 50
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0], io_error[32], zero pad
  input  logic [OP_W-1:0]        in_tuser,   // operation[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[1:0], block[33:2], word_index[39:34],
                                             // free_total[71:40], dirty[72], zero pad
  output logic [1:0]             out_tuser,  // kind[1:0]
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [WORD_W-1:0]      cfg_wdata
);

  cmd_t              cmd;
  stat_t             stat;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_block;
  logic [CNT_W-1:0]  out_word_index;
  logic [WORD_W-1:0] out_free_total;
  logic              out_dirty;

  cfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cfb_dp #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_tuser),
    .in_value       (in_tdata[WORD_W-1:0]),
    .in_err         (in_tdata[WORD_W]),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_kind       (out_tuser),
    .out_status     (out_status),
    .out_block      (out_block),
    .out_word_index (out_word_index),
    .out_last       (out_tlast),
    .out_free_total (out_free_total),
    .out_dirty      (out_dirty)
  );

  assign out_tdata = {7'd0, out_dirty, out_free_total, out_word_index, out_block, out_status};

endmodule
